// ===== design/tnsr_pkg.sv =====
`default_nettype none

package tnsr_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RAND_W   = 16;
    localparam int DEPTH_W  = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int CHANNELS_DEFAULT = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 5'd24;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd24;
    localparam logic               ENABLE_RESET = 1'b1;

    // Q2.14 noise shaping coefficients, magnitudes
    localparam logic [15:0] COEF_RECENT = 16'd33309;
    localparam logic [15:0] COEF_OLDER  = 16'd29486;

    // register index, taken from paddr[2]
    localparam logic REG_BIT_DEPTH = 1'b0;
    localparam logic REG_ENABLE    = 1'b1;

    typedef struct packed {
        logic [DEPTH_W-1:0] bit_depth;
        logic               enable;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/tnsr_mem.sv =====
`default_nettype none

module tnsr_mem #(
    parameter int DEPTH = 2,
    parameter int AW    = 1,
    parameter int DW    = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/tnsr_regs.sv =====
`default_nettype none

module tnsr_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tnsr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tnsr_pkg::PDATA_W-1:0] pwdata,
    output logic      [tnsr_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output tnsr_pkg::cfg_t                    cfg
);

    logic [tnsr_pkg::DEPTH_W-1:0] bit_depth_reg;
    logic                         enable_reg;
    logic                         wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= tnsr_pkg::DEPTH_RESET;
            enable_reg    <= tnsr_pkg::ENABLE_RESET;
        end
        else if (wr_stb)
        begin
            case (paddr[2])
                tnsr_pkg::REG_BIT_DEPTH: bit_depth_reg <= pwdata[tnsr_pkg::DEPTH_W-1:0];
                tnsr_pkg::REG_ENABLE:    enable_reg    <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            tnsr_pkg::REG_BIT_DEPTH:
                prdata = {{(tnsr_pkg::PDATA_W - tnsr_pkg::DEPTH_W){1'b0}}, bit_depth_reg};
            tnsr_pkg::REG_ENABLE:
                prdata = {{(tnsr_pkg::PDATA_W - 1){1'b0}}, enable_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.bit_depth = bit_depth_reg;
    assign cfg.enable    = enable_reg;

endmodule

`default_nettype wire

// ===== design/tnsr_datapath.sv =====
`default_nettype none

module tnsr_datapath #(
    parameter int CHANNELS = tnsr_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire tnsr_pkg::cfg_t                       cfg,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [tnsr_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic                                 channel,
    input  wire logic signed [tnsr_pkg::RAND_W-1:0]   random_a,
    input  wire logic signed [tnsr_pkg::RAND_W-1:0]   random_b,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed      [tnsr_pkg::SAMPLE_W-1:0] sample_out
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW   = tnsr_pkg::SAMPLE_W;
    localparam int DW   = tnsr_pkg::DEPTH_W;
    localparam int RSW  = tnsr_pkg::RAND_W + 1;
    localparam int PW   = SW + 17;
    localparam int DTW  = RSW + 22;
    localparam int VW   = 50;
    localparam int QW   = VW - 14;
    localparam int EW   = QW + 1;

    localparam logic [13:0] HALF_LSB = 14'd8192;

    function automatic logic [SW-1:0] sat_word(input logic [EW-1:0] v);
        logic [SW-1:0] r;
        if (v[EW-1:SW-1] == {(EW - SW + 1){1'b0}} || v[EW-1:SW-1] == {(EW - SW + 1){1'b1}})
            r = v[SW-1:0];
        else if (v[EW-1])
            r = {1'b1, {(SW - 1){1'b0}}};
        else
            r = {1'b0, {(SW - 1){1'b1}}};
        return r;
    endfunction

    // ---------------- accept side
    logic                 advance;
    logic                 accept;
    logic                 hazard;
    logic [CH_W-1:0]      in_ch;
    logic signed [RSW-1:0] in_dsum;
    logic [DW-1:0]        in_depth;

    // ---------------- stage registers
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                 s1_en_reg, s2_en_reg, s3_en_reg, s4_en_reg;
    logic [CH_W-1:0]      s1_ch_reg, s2_ch_reg, s3_ch_reg, s4_ch_reg;
    logic [SW-1:0]        s1_x_reg, s2_x_reg, s3_x_reg, s4_x_reg;
    logic [DW-1:0]        s1_d_reg, s2_d_reg, s3_d_reg;
    logic signed [RSW-1:0] s1_dsum_reg;
    logic signed [PW-1:0] s2_pr_reg, s2_po_reg;
    logic signed [DTW-1:0] s2_dith_reg;
    logic [SW-1:0]        s2_er_reg, s3_er_reg, s4_er_reg;
    logic [VW-1:0]        s3_shaped_reg, s3_v_reg, s4_shaped_reg;
    logic [VW-1:0]        s4_quant_reg;

    logic                 out_valid_reg;
    logic [SW-1:0]        sample_out_reg;

    logic                 byp_valid_reg;
    logic [CH_W-1:0]      byp_ch_reg;
    logic [2*SW-1:0]      byp_data_reg;

    // ---------------- memory
    logic [2*SW-1:0]      rd_data;
    logic                 wr_en;
    logic [2*SW-1:0]      wr_data;

    tnsr_mem #(
        .DEPTH (CHANNELS),
        .AW    (CH_W),
        .DW    (2 * SW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_ch),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s4_ch_reg),
        .wr_data (wr_data)
    );

    assign in_ch   = (CHANNELS == 1) ? '0 : CH_W'(channel);
    assign in_dsum = {random_a[tnsr_pkg::RAND_W-1], random_a}
                   + {random_b[tnsr_pkg::RAND_W-1], random_b};

    always_comb
    begin
        if (cfg.bit_depth < tnsr_pkg::DEPTH_MIN)
            in_depth = tnsr_pkg::DEPTH_MIN;
        else if (cfg.bit_depth > tnsr_pkg::DEPTH_MAX)
            in_depth = tnsr_pkg::DEPTH_MAX;
        else
            in_depth = cfg.bit_depth;
    end

    // same-channel item still ahead of the write port: hold off
    assign hazard = cfg.enable && (
                    (s1_valid_reg && s1_en_reg && s1_ch_reg == in_ch) ||
                    (s2_valid_reg && s2_en_reg && s2_ch_reg == in_ch) ||
                    (s3_valid_reg && s3_en_reg && s3_ch_reg == in_ch));

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance && !hazard;
    assign accept   = in_valid && in_ready;

    // ---------------- stage 1: error fetch, products, dither
    logic [2*SW-1:0]       s1_hist;
    logic signed [SW-1:0]  s1_er, s1_eo;
    logic signed [PW-1:0]  s1_pr, s1_po;
    logic [DW-1:0]         s1_sh;
    logic signed [DTW-1:0] s1_dith;

    assign s1_hist = (byp_valid_reg && byp_ch_reg == s1_ch_reg) ? byp_data_reg : rd_data;
    assign s1_er   = s1_hist[2*SW-1:SW];
    assign s1_eo   = s1_hist[SW-1:0];
    assign s1_pr   = $signed({1'b0, tnsr_pkg::COEF_RECENT}) * s1_er;
    assign s1_po   = $signed({1'b0, tnsr_pkg::COEF_OLDER}) * s1_eo;
    assign s1_sh   = 5'd30 - s1_d_reg;
    assign s1_dith = $signed({{(DTW - RSW){s1_dsum_reg[RSW-1]}}, s1_dsum_reg}) <<< s1_sh;

    // ---------------- stage 2: shaped and dithered sums
    logic signed [VW-1:0] s2_xs, s2_pre, s2_poe, s2_dte;
    logic [VW-1:0]        s2_shaped, s2_v;

    assign s2_xs     = {{(VW - SW - 14){s2_x_reg[SW-1]}}, s2_x_reg, 14'd0};
    assign s2_pre    = {{(VW - PW){s2_pr_reg[PW-1]}}, s2_pr_reg};
    assign s2_poe    = {{(VW - PW){s2_po_reg[PW-1]}}, s2_po_reg};
    assign s2_dte    = {{(VW - DTW){s2_dith_reg[DTW-1]}}, s2_dith_reg};
    assign s2_shaped = s2_xs - s2_pre + s2_poe;
    assign s2_v      = s2_xs - s2_pre + s2_poe + s2_dte;

    // ---------------- stage 3: round half away from zero at 2^(46-depth)
    logic [5:0]    s3_qk;
    logic [VW-1:0] s3_half, s3_mask, s3_rnd, s3_quant;

    assign s3_qk    = 6'd46 - {1'b0, s3_d_reg};
    assign s3_half  = VW'(1) << (s3_qk - 6'd1);
    assign s3_mask  = (VW'(1) << s3_qk) - VW'(1);
    assign s3_rnd   = s3_v_reg[VW-1] ? s3_half - VW'(1) : s3_half;
    assign s3_quant = (s3_v_reg + s3_rnd) & ~s3_mask;

    // ---------------- stage 4: new error, output, write back
    logic [QW-1:0] s4_q, s4_shi;
    logic [13:0]   s4_slo;
    logic [EW-1:0] s4_diff, s4_diff_m1, s4_errw;
    logic          s4_dec;
    logic [SW-1:0] s4_err, s4_out;

    assign s4_q       = s4_quant_reg[VW-1:14];
    assign s4_shi     = s4_shaped_reg[VW-1:14];
    assign s4_slo     = s4_shaped_reg[13:0];
    assign s4_diff    = {s4_q[QW-1], s4_q} - {s4_shi[QW-1], s4_shi};
    assign s4_diff_m1 = {s4_q[QW-1], s4_q} + ~{s4_shi[QW-1], s4_shi};
    assign s4_dec     = (s4_slo > HALF_LSB) ||
                        (s4_slo == HALF_LSB && (s4_diff[EW-1] || s4_diff == '0));
    assign s4_errw    = s4_dec ? s4_diff_m1 : s4_diff;
    assign s4_err     = sat_word(s4_errw);
    assign s4_out     = s4_en_reg ? sat_word({s4_q[QW-1], s4_q}) : s4_x_reg;

    assign wr_en   = advance && s4_valid_reg && s4_en_reg;
    assign wr_data = {s4_err, s4_er_reg};

    // ---------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg  <= accept;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
            end
            if (wr_en)
            begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_en_reg   <= cfg.enable;
            s1_ch_reg   <= in_ch;
            s1_x_reg    <= sample_in;
            s1_d_reg    <= in_depth;
            s1_dsum_reg <= in_dsum;

            s2_en_reg   <= s1_en_reg;
            s2_ch_reg   <= s1_ch_reg;
            s2_x_reg    <= s1_x_reg;
            s2_d_reg    <= s1_d_reg;
            s2_pr_reg   <= s1_pr;
            s2_po_reg   <= s1_po;
            s2_dith_reg <= s1_dith;
            s2_er_reg   <= s1_er;

            s3_en_reg     <= s2_en_reg;
            s3_ch_reg     <= s2_ch_reg;
            s3_x_reg      <= s2_x_reg;
            s3_d_reg      <= s2_d_reg;
            s3_shaped_reg <= s2_shaped;
            s3_v_reg      <= s2_v;
            s3_er_reg     <= s2_er_reg;

            s4_en_reg     <= s3_en_reg;
            s4_ch_reg     <= s3_ch_reg;
            s4_x_reg      <= s3_x_reg;
            s4_shaped_reg <= s3_shaped_reg;
            s4_quant_reg  <= s3_quant;
            s4_er_reg     <= s3_er_reg;

            sample_out_reg <= s4_out;
        end
        if (wr_en)
        begin
            byp_ch_reg   <= s4_ch_reg;
            byp_data_reg <= wr_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

`default_nettype wire

// ===== design/tpdf_noise_shaped_requantizer_top.sv =====
`default_nettype none

// TPDF dither with second-order noise shaping. Each transaction carries a Q1.31
// sample, a channel number and two random values; one requantized sample comes
// back per transaction, in order, through stage registers s1 to s4 and an output
// register. The per-channel error history sits in a small synchronous RAM read at
// acceptance and written back from stage 4, so transactions on different
// channels are taken every cycle unless the output side is stalled, while a
// transaction on a channel still being shaped waits until that channel's
// write-back. bit_depth (offset 0x0) and enable (offset 0x4) must be written
// only while the block is idle; the block itself does not enforce this. With
// enable low samples pass through unchanged and the error history is kept.
// Reset clears the history.
module tpdf_noise_shaped_requantizer_top #(
    parameter int CHANNELS = tnsr_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [tnsr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic        [tnsr_pkg::PDATA_W-1:0]  pwdata,
    output logic             [tnsr_pkg::PDATA_W-1:0]  prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [tnsr_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic                                 channel,
    input  wire logic signed [tnsr_pkg::RAND_W-1:0]   random_a,
    input  wire logic signed [tnsr_pkg::RAND_W-1:0]   random_b,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed      [tnsr_pkg::SAMPLE_W-1:0] sample_out
);

    tnsr_pkg::cfg_t cfg;

    tnsr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tnsr_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .channel    (channel),
        .random_a   (random_a),
        .random_b   (random_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic        [tnsr_pkg::PADDR_W-1:0]  paddr;
    logic        [tnsr_pkg::PDATA_W-1:0]  pwdata;
    logic        [tnsr_pkg::PDATA_W-1:0]  prdata;
    logic                                 pready;
    logic                                 in_valid;
    logic                                 in_ready;
    logic signed [tnsr_pkg::SAMPLE_W-1:0] sample_in;
    logic                                 channel;
    logic signed [tnsr_pkg::RAND_W-1:0]   random_a;
    logic signed [tnsr_pkg::RAND_W-1:0]   random_b;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [tnsr_pkg::SAMPLE_W-1:0] sample_out;

    tpdf_noise_shaped_requantizer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .channel    (channel),
        .random_a   (random_a),
        .random_b   (random_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    always #5 clk = ~clk;

    // shaper configuration and per-channel error history
    logic [tnsr_pkg::DEPTH_W-1:0]         depth_cfg  = tnsr_pkg::DEPTH_RESET;
    logic                                 enable_cfg = tnsr_pkg::ENABLE_RESET;
    logic signed [tnsr_pkg::SAMPLE_W-1:0] err_recent [2] = '{0, 0};
    logic signed [tnsr_pkg::SAMPLE_W-1:0] err_older  [2] = '{0, 0};

    logic signed [tnsr_pkg::SAMPLE_W-1:0] expected_samples [$];
    int                                   mismatch_count = 0;
    int                                   cycles = 0;
    int                                   idle_pct = 0;
    int                                   stall_pct = 0;

    function automatic longint round_away(input longint v, input int k);
        longint unsigned mag;
        longint unsigned r;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        r = (mag + (64'd1 << (k - 1))) >> k;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // predicts one output sample and, with enable set, advances the channel's error history
    function automatic logic signed [31:0] requantize(
        input logic signed [31:0] s,
        input logic               ch,
        input logic signed [15:0] ra,
        input logic signed [15:0] rb
    );
        longint x;
        longint er;
        longint eo;
        longint sa;
        longint sb;
        longint shaped;
        longint dither;
        longint q;
        longint err;
        int     d;
        int     qk;
        if (!enable_cfg)
            return s;
        d = int'(depth_cfg);
        if (d < int'(tnsr_pkg::DEPTH_MIN))
            d = int'(tnsr_pkg::DEPTH_MIN);
        if (d > int'(tnsr_pkg::DEPTH_MAX))
            d = int'(tnsr_pkg::DEPTH_MAX);
        x = s;
        er = err_recent[ch];
        eo = err_older[ch];
        sa = ra;
        sb = rb;
        shaped = (x <<< 14) - longint'(tnsr_pkg::COEF_RECENT) * er
               + longint'(tnsr_pkg::COEF_OLDER) * eo;
        dither = (sa + sb) <<< (30 - d);
        qk = 46 - d;
        q = round_away(shaped + dither, qk);
        err = round_away((q <<< qk) - shaped, 14);
        err_older[ch] = err_recent[ch];
        err_recent[ch] = sat32(err);
        return sat32(q <<< (32 - d));
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 30)
            $display("ERROR %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_samples.push_back(requantize(sample_in, channel, random_a, random_b));
    end

    always @(posedge clk)
    begin
        logic signed [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch($sformatf("unexpected transaction, sample_out %h", sample_out));
            else
            begin
                want = expected_samples.pop_front();
                if (sample_out !== want)
                    report_mismatch($sformatf("sample_out %h, expected %h", sample_out, want));
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_sample(
        input logic signed [31:0] s,
        input logic               ch,
        input logic signed [15:0] ra,
        input logic signed [15:0] rb
    );
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        channel   <= ch;
        random_a  <= ra;
        random_b  <= rb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // the last accepted transaction is queued by the monitor at this same edge
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == tnsr_pkg::REG_BIT_DEPTH)
            depth_cfg = value[tnsr_pkg::DEPTH_W-1:0];
        else
            enable_cfg = value[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int depth, input logic en);
        drain();
        reg_write(tnsr_pkg::REG_BIT_DEPTH, depth);
        reg_write(tnsr_pkg::REG_ENABLE, {31'd0, en});
    endtask

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'sh7FFFFFFF - $signed($urandom_range(1 << 20));
            2: return 32'sh80000000 + $signed($urandom_range(1 << 20));
            default: return $signed($urandom_range(131071)) - 65536;
        endcase
    endfunction

    task automatic test_reset_extremes;
        send_sample(32'sh7FFFFFFF, 1'b0, 16'sh7FFF, 16'sh7FFF);
        send_sample(32'sh80000000, 1'b1, 16'sh8000, 16'sh8000);
        send_sample(32'sh00000000, 1'b0, 16'sh8000, 16'sh7FFF);
        send_sample(32'shFFFFFFFF, 1'b1, 16'sh7FFF, 16'sh8000);
        send_sample(32'sh00000001, 1'b0, 16'sh0000, 16'sh0000);
        send_sample(32'sh40000000, 1'b1, 16'shFFFF, 16'sh0001);
        send_sample(32'shC0000000, 1'b0, 16'sh1234, 16'shEDCB);
        send_sample(32'sh00000080, 1'b1, 16'sh0000, 16'sh0000);
    endtask

    task automatic test_depth_limits;
        int depths [4] = '{0, 7, 25, 31};
        foreach (depths[i])
        begin
            configure(depths[i], 1'b1);
            send_sample($urandom, 1'b0, 16'($urandom), 16'($urandom));
            send_sample($urandom, 1'b1, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_saturation;
        configure(8, 1'b1);
        send_sample(32'sh7FFFFFFF, 1'b0, 16'sh7FFF, 16'sh7FFF);
        send_sample(32'sh80000000, 1'b1, 16'sh8000, 16'sh8000);
        send_sample(32'sh7FFFFF00, 1'b0, 16'sh7FFF, 16'sh7FFF);
        send_sample(32'sh80000100, 1'b1, 16'sh8000, 16'sh8000);
    endtask

    task automatic test_bypass;
        configure(16, 1'b0);
        send_sample(32'sh7FFFFFFF, 1'b0, 16'sh7FFF, 16'sh8000);
        send_sample(32'sh80000000, 1'b1, 16'sh8000, 16'sh7FFF);
        send_sample(32'sh12345678, 1'b0, 16'sh0000, 16'sh0000);
        configure(16, 1'b1);
        send_sample(32'sh12345678, 1'b0, 16'sh0101, 16'shF0F0);
    endtask

    task automatic test_random_phase(
        input int   count,
        input int   idle,
        input int   stall,
        input int   depth,
        input logic en,
        input bit   hold_off
    );
        configure(depth, en);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            if (hold_off && i == count / 2)
                drain();
            send_sample(pick_sample(), 1'($urandom), 16'($urandom), 16'($urandom));
        end
        drain();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        sample_in <= '0;
        channel   <= 1'b0;
        random_a  <= '0;
        random_b  <= '0;
        out_ready <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_extremes();
        test_depth_limits();
        test_saturation();
        test_bypass();
        test_random_phase(300, 0, 0, 24, 1'b1, 1'b0);
        test_random_phase(250, 88, 0, 8, 1'b1, 1'b0);
        test_random_phase(250, 0, 88, 16, 1'b1, 1'b0);
        test_random_phase(250, 33, 33, 31, 1'b1, 1'b1);
        test_random_phase(100, 0, 0, 20, 1'b0, 1'b0);
        test_random_phase(150, 33, 33, 12, 1'b1, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/tnsr_pkg.sv
design/tnsr_mem.sv
design/tnsr_regs.sv
design/tnsr_datapath.sv
design/tpdf_noise_shaped_requantizer_top.sv
sim/tb_top.sv
